// File: rtl/core/bei_pkg.sv
// ----------------------------------------------------------------------------
// bei_pkg: shared constants for the binomial efficiency interval block
// Default count and fraction widths used by the top level parameters.
// ----------------------------------------------------------------------------
`default_nettype none

package bei_pkg;

  localparam int unsigned CountBitsDef = 32;
  localparam int unsigned FracBitsDef  = 16;

endpackage

`default_nettype wire

// File: rtl/core/bei_div.sv
// ----------------------------------------------------------------------------
// bei_div: pipelined restoring divider
// One quotient bit per register stage, Q_W stages. The quotient must be
// below 2^Q_W; a side tag travels with each request.
// ----------------------------------------------------------------------------
`default_nettype none

module bei_div
  import bei_pkg::*;
#(
  parameter int unsigned NUM_W = 66,
  parameter int unsigned DEN_W = 65,
  parameter int unsigned Q_W   = 17,
  parameter int unsigned TAG_W = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  input  logic [TAG_W-1:0] tag_i,
  output logic             valid_o,
  output logic [Q_W-1:0]   quot_o,
  output logic [TAG_W-1:0] tag_o
);

  logic [DEN_W-1:0] rem_w [Q_W+1];
  logic [DEN_W-1:0] den_w [Q_W+1];
  logic [Q_W-1:0]   nb_w  [Q_W+1];
  logic [Q_W-1:0]   qt_w  [Q_W+1];
  logic [TAG_W-1:0] tag_w [Q_W+1];
  logic             vld_w [Q_W+1];

  // upper numerator bits start as the partial remainder
  assign rem_w[0] = DEN_W'(num_i >> Q_W);
  assign den_w[0] = den_i;
  assign nb_w[0]  = num_i[Q_W-1:0];
  assign qt_w[0]  = '0;
  assign tag_w[0] = tag_i;
  assign vld_w[0] = valid_i;

  for (genvar s = 0; s < Q_W; s++) begin : g_stage
    logic [DEN_W:0]   cur;
    logic [DEN_W:0]   diff;
    logic             fits;
    logic [DEN_W-1:0] rem_d;
    logic [DEN_W-1:0] rem_q;
    logic [DEN_W-1:0] den_q;
    logic [Q_W-1:0]   nb_q;
    logic [Q_W-1:0]   qt_q;
    logic [TAG_W-1:0] tag_q;
    logic             vld_q;

    always_comb begin
      cur   = {rem_w[s], nb_w[s][Q_W-1]};
      diff  = cur - {1'b0, den_w[s]};
      fits  = (cur >= {1'b0, den_w[s]});
      rem_d = fits ? diff[DEN_W-1:0] : cur[DEN_W-1:0];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q <= 1'b0;
      end else if (en_i) begin
        vld_q <= vld_w[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q <= rem_d;
        den_q <= den_w[s];
        nb_q  <= nb_w[s] << 1;
        qt_q  <= {qt_w[s][Q_W-2:0], fits};
        tag_q <= tag_w[s];
      end
    end

    assign rem_w[s+1] = rem_q;
    assign den_w[s+1] = den_q;
    assign nb_w[s+1]  = nb_q;
    assign qt_w[s+1]  = qt_q;
    assign tag_w[s+1] = tag_q;
    assign vld_w[s+1] = vld_q;
  end

  assign valid_o = vld_w[Q_W];
  assign quot_o  = qt_w[Q_W];
  assign tag_o   = tag_w[Q_W];

endmodule

`default_nettype wire

// File: rtl/core/bei_sqrt.sv
// ----------------------------------------------------------------------------
// bei_sqrt: pipelined integer square root
// Digit-by-digit method, one root bit per register stage; the root is the
// floor of the square root of the radicand. A side tag travels along.
// ----------------------------------------------------------------------------
`default_nettype none

module bei_sqrt
  import bei_pkg::*;
#(
  parameter int unsigned IN_W  = 130,
  parameter int unsigned TAG_W = 1,
  localparam int unsigned RT_W = (IN_W + 1) / 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [IN_W-1:0]  rad_i,
  input  logic [TAG_W-1:0] tag_i,
  output logic             valid_o,
  output logic [RT_W-1:0]  root_o,
  output logic [TAG_W-1:0] tag_o
);

  localparam int unsigned PadW = 2 * RT_W;
  localparam int unsigned RemW = RT_W + 2;

  logic [RemW-1:0]  rem_w  [RT_W+1];
  logic [RT_W-1:0]  root_w [RT_W+1];
  logic [PadW-1:0]  rad_w  [RT_W+1];
  logic [TAG_W-1:0] tag_w  [RT_W+1];
  logic             vld_w  [RT_W+1];

  assign rem_w[0]  = '0;
  assign root_w[0] = '0;
  assign rad_w[0]  = PadW'(rad_i);
  assign tag_w[0]  = tag_i;
  assign vld_w[0]  = valid_i;

  for (genvar s = 0; s < RT_W; s++) begin : g_stage
    logic [RemW-1:0]  cur;
    logic [RemW-1:0]  trial;
    logic             fits;
    logic [RemW-1:0]  rem_d;
    logic [RemW-1:0]  rem_q;
    logic [RT_W-1:0]  root_q;
    logic [PadW-1:0]  rad_q;
    logic [TAG_W-1:0] tag_q;
    logic             vld_q;

    // remainder stays below 2*root + 1, so its top two bits shift out as zero
    always_comb begin
      cur   = {rem_w[s][RemW-3:0], rad_w[s][PadW-1 -: 2]};
      trial = {root_w[s], 2'b01};
      fits  = (cur >= trial);
      rem_d = fits ? (cur - trial) : cur;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q <= 1'b0;
      end else if (en_i) begin
        vld_q <= vld_w[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q  <= rem_d;
        root_q <= {root_w[s][RT_W-2:0], fits};
        rad_q  <= rad_w[s] << 2;
        tag_q  <= tag_w[s];
      end
    end

    assign rem_w[s+1]  = rem_q;
    assign root_w[s+1] = root_q;
    assign rad_w[s+1]  = rad_q;
    assign tag_w[s+1]  = tag_q;
    assign vld_w[s+1]  = vld_q;
  end

  assign valid_o = vld_w[RT_W];
  assign root_o  = root_w[RT_W];
  assign tag_o   = tag_w[RT_W];

endmodule

`default_nettype wire

// File: rtl/core/binomial_efficiency_interval.sv
// Pipeline: a capture stage, four arithmetic stages, one square-root stage per
// root bit, one numerator stage, one divider stage per quotient bit and the
// output register. Throughput: one request per cycle; one global stall freezes
// every stage while the output register holds an untaken result.
// Reset clears all valid bits; the data path holds no reset state.
// ----------------------------------------------------------------------------
// binomial_efficiency_interval: Wilson score interval (z = 1) per bin
// Efficiency k/n and upper/lower interval errors as unsigned Q1.FRAC_BITS fractions.
// ----------------------------------------------------------------------------
`default_nettype none

module binomial_efficiency_interval
  import bei_pkg::*;
#(
  parameter int unsigned COUNT_BITS = CountBitsDef,
  parameter int unsigned FRAC_BITS  = FracBitsDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [COUNT_BITS-1:0] n_total_i,
  input  logic [COUNT_BITS-1:0] n_passed_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [FRAC_BITS:0]    efficiency_o,
  output logic [FRAC_BITS:0]    error_up_o,
  output logic [FRAC_BITS:0]    error_down_o,
  output logic                  invalid_o
);

  localparam int unsigned CB    = COUNT_BITS;
  localparam int unsigned FB    = FRAC_BITS;
  localparam int unsigned QW    = FB + 1;          // quotient bits, result <= 1.0
  localparam int unsigned QQW   = 2 * CB + 1;      // width of 2n(n+1)
  localparam int unsigned XW    = 3 * CB + 1 + 2 * FB; // n(4k(n-k)+n) * 4^F
  localparam int unsigned RW    = (XW + 1) / 2;    // root width
  localparam int unsigned NUMW  = RW + 1;          // S +- |n-2k|*2^F
  localparam int unsigned ENUMW = CB + FB;         // k * 2^F
  localparam int unsigned TAGW  = 2 * CB + QQW + 2;

  // global stall: every stage moves when the output register can take a result
  logic en;
  logic out_vld_q;

  assign en         = !out_vld_q || out_ready_i;
  assign in_ready_o = en;

  // stage A: capture the request
  logic          vld_a_q;
  logic [CB-1:0] n_a_q, k_a_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q <= 1'b0;
    end else if (en) begin
      vld_a_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      n_a_q <= n_total_i;
      k_a_q <= n_passed_i;
    end
  end

  // stage B: k(n-k), n(n+1), special cases
  logic            vld_b_q, inv_b_q, zero_b_q;
  logic [CB-1:0]   n_b_q, k_b_q;
  logic [2*CB-1:0] p1_d, p1_b_q, nn_d;
  logic [QQW-1:0]  qq_b_q;

  assign p1_d = (2*CB)'(k_a_q) * (2*CB)'(n_a_q - k_a_q);
  assign nn_d = (2*CB)'(n_a_q) * ((2*CB)'(n_a_q) + (2*CB)'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_b_q <= 1'b0;
    end else if (en) begin
      vld_b_q <= vld_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      n_b_q    <= n_a_q;
      k_b_q    <= k_a_q;
      p1_b_q   <= p1_d;
      qq_b_q   <= {nn_d, 1'b0};
      inv_b_q  <= (k_a_q > n_a_q);
      zero_b_q <= (n_a_q == '0);
    end
  end

  // stage C: a = 4k(n-k) + n
  logic            vld_c_q, inv_c_q, zero_c_q;
  logic [CB-1:0]   n_c_q, k_c_q;
  logic [QQW-1:0]  qq_c_q;
  logic [2*CB:0]   a_c_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_c_q <= 1'b0;
    end else if (en) begin
      vld_c_q <= vld_b_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      n_c_q    <= n_b_q;
      k_c_q    <= k_b_q;
      qq_c_q   <= qq_b_q;
      inv_c_q  <= inv_b_q;
      zero_c_q <= zero_b_q;
      a_c_q    <= (2*CB+1)'({p1_b_q, 2'b00}) + (2*CB+1)'(n_b_q);
    end
  end

  // stage D: a * n as two partial products
  logic            vld_d_q, inv_d_q, zero_d_q;
  logic [CB-1:0]   n_d_q, k_d_q;
  logic [QQW-1:0]  qq_d_q;
  logic [2*CB-1:0] pl_d_q;
  logic [2*CB:0]   ph_d_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_d_q <= 1'b0;
    end else if (en) begin
      vld_d_q <= vld_c_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      n_d_q    <= n_c_q;
      k_d_q    <= k_c_q;
      qq_d_q   <= qq_c_q;
      inv_d_q  <= inv_c_q;
      zero_d_q <= zero_c_q;
      pl_d_q   <= (2*CB)'(a_c_q[CB-1:0]) * (2*CB)'(n_c_q);
      ph_d_q   <= (2*CB+1)'(a_c_q[2*CB:CB]) * (2*CB+1)'(n_c_q);
    end
  end

  // stage E: merge partial products
  logic            vld_e_q, inv_e_q, zero_e_q;
  logic [CB-1:0]   n_e_q, k_e_q;
  logic [QQW-1:0]  qq_e_q;
  logic [3*CB:0]   x_e_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_e_q <= 1'b0;
    end else if (en) begin
      vld_e_q <= vld_d_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      n_e_q    <= n_d_q;
      k_e_q    <= k_d_q;
      qq_e_q   <= qq_d_q;
      inv_e_q  <= inv_d_q;
      zero_e_q <= zero_d_q;
      x_e_q    <= (3*CB+1)'(pl_d_q) + ((3*CB+1)'(ph_d_q) << CB);
    end
  end

  // square root of x * 4^F gives S scaled by 2^F
  logic            sq_vld;
  logic [RW-1:0]   sq_root;
  logic [TAGW-1:0] sq_tag;
  logic [CB-1:0]   n_s, k_s;
  logic [QQW-1:0]  qq_s;
  logic            inv_s, zero_s;

  bei_sqrt #(
    .IN_W  (XW),
    .TAG_W (TAGW)
  ) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (vld_e_q),
    .rad_i   ({x_e_q, (2*FB)'(0)}),
    .tag_i   ({n_e_q, k_e_q, qq_e_q, inv_e_q, zero_e_q}),
    .valid_o (sq_vld),
    .root_o  (sq_root),
    .tag_o   (sq_tag)
  );

  assign {n_s, k_s, qq_s, inv_s, zero_s} = sq_tag;

  // stage F: numerators of the two bounds and of the efficiency
  logic            lower_half;
  logic [CB:0]     two_k, gap_k;
  logic [NUMW-1:0] dsh, num_sum, num_dif;

  always_comb begin
    two_k      = (CB+1)'(k_s) << 1;
    lower_half = ((CB+1)'(n_s) >= two_k);
    gap_k      = lower_half ? ((CB+1)'(n_s) - two_k) : (two_k - (CB+1)'(n_s));
    dsh        = NUMW'(gap_k) << FB;
    num_sum    = NUMW'(sq_root) + dsh;
    num_dif    = NUMW'(sq_root) - dsh;
  end

  logic             vld_f_q, inv_f_q, kill_f_q;
  logic [NUMW-1:0]  up_f_q, dn_f_q;
  logic [QQW-1:0]   qq_f_q;
  logic [CB-1:0]    n_f_q;
  logic [ENUMW-1:0] en_f_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_f_q <= 1'b0;
    end else if (en) begin
      vld_f_q <= sq_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      up_f_q   <= lower_half ? num_sum : num_dif;
      dn_f_q   <= lower_half ? num_dif : num_sum;
      qq_f_q   <= qq_s;
      n_f_q    <= n_s;
      en_f_q   <= ENUMW'(k_s) << FB;
      inv_f_q  <= inv_s;
      kill_f_q <= inv_s | zero_s;
    end
  end

  // three dividers in lockstep
  logic          ve, vu, vd, inv_o_w, kill_u, kill_d;
  logic [QW-1:0] q_eff, q_up, q_dn;

  bei_div #(
    .NUM_W (ENUMW),
    .DEN_W (CB),
    .Q_W   (QW),
    .TAG_W (1)
  ) u_div_eff (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (vld_f_q),
    .num_i   (en_f_q),
    .den_i   (n_f_q),
    .tag_i   (inv_f_q),
    .valid_o (ve),
    .quot_o  (q_eff),
    .tag_o   (inv_o_w)
  );

  bei_div #(
    .NUM_W (NUMW),
    .DEN_W (QQW),
    .Q_W   (QW),
    .TAG_W (1)
  ) u_div_up (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (vld_f_q),
    .num_i   (up_f_q),
    .den_i   (qq_f_q),
    .tag_i   (kill_f_q),
    .valid_o (vu),
    .quot_o  (q_up),
    .tag_o   (kill_u)
  );

  bei_div #(
    .NUM_W (NUMW),
    .DEN_W (QQW),
    .Q_W   (QW),
    .TAG_W (1)
  ) u_div_dn (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (vld_f_q),
    .num_i   (dn_f_q),
    .den_i   (qq_f_q),
    .tag_i   (kill_f_q),
    .valid_o (vd),
    .quot_o  (q_dn),
    .tag_o   (kill_d)
  );

  // output register; empty or invalid bins read as zero
  logic          kill;
  logic [QW-1:0] eff_q, up_q, dn_q;
  logic          inv_q;

  assign kill = kill_u | kill_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= ve & vu & vd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      eff_q <= kill ? '0 : q_eff;
      up_q  <= kill ? '0 : q_up;
      dn_q  <= kill ? '0 : q_dn;
      inv_q <= inv_o_w;
    end
  end

  assign out_valid_o  = out_vld_q;
  assign efficiency_o = eff_q;
  assign error_up_o   = up_q;
  assign error_down_o = dn_q;
  assign invalid_o    = inv_q;

endmodule

`default_nettype wire

// File: tb/bei_result_checker.sv
// ----------------------------------------------------------------------------
// bei_result_checker: bin result predictor and comparator
// Watches both channels, computes the Wilson interval (z = 1) for each
// accepted bin and compares each accepted result against the oldest one.
// ----------------------------------------------------------------------------
`default_nettype none

module bei_result_checker
  import bei_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  input  logic                    in_ready_i,
  input  logic [CountBitsDef-1:0] n_total_i,
  input  logic [CountBitsDef-1:0] n_passed_i,
  input  logic                    out_valid_i,
  input  logic                    out_ready_i,
  input  logic [FracBitsDef:0]    efficiency_i,
  input  logic [FracBitsDef:0]    error_up_i,
  input  logic [FracBitsDef:0]    error_down_i,
  input  logic                    invalid_i,
  output int                      fail_count_o,
  output int                      pending_o
);

  localparam int unsigned F = FracBitsDef;

  typedef struct packed {
    logic [F:0] eff;
    logic [F:0] up;
    logic [F:0] down;
    logic       inv;
  } bin_result_t;

  bin_result_t wilson_q[$];
  int          fails = 0;

  assign fail_count_o = fails;
  assign pending_o    = wilson_q.size();

  function automatic logic [159:0] isqrt160(logic [159:0] a);
    logic [159:0] res;
    logic [159:0] t;
    res = '0;
    for (int i = 79; i >= 0; i--) begin
      t = res | (160'd1 << i);
      if (t * t <= a) res = t;
    end
    return res;
  endfunction

  function automatic bin_result_t wilson_bin(logic [31:0] n_in, logic [31:0] k_in);
    bin_result_t  r;
    logic [159:0] n;
    logic [159:0] k;
    logic [159:0] s;
    logic [159:0] q;
    logic [159:0] d;
    logic [159:0] hi;
    logic [159:0] lo;
    r = '0;
    n = 160'(n_in);
    k = 160'(k_in);
    if (k > n) begin
      r.inv = 1'b1;
      return r;
    end
    if (n == 0) return r;
    r.eff = (F + 1)'((k << F) / n);
    s = isqrt160(((((k * (n - k)) << 2) + n) * n) << (2 * F));
    q = ((n + 1) * n) << 1;
    // d is |n - 2k| scaled; sign picks which bound gets the sum
    if (n >= 2 * k) begin
      d  = (n - 2 * k) << F;
      hi = (s + d) / q;
      lo = (s - d) / q;
    end else begin
      d  = (2 * k - n) << F;
      hi = (s - d) / q;
      lo = (s + d) / q;
    end
    r.up   = (F + 1)'(hi);
    r.down = (F + 1)'(lo);
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d, expected %0d", what, got, want);
    fails++;
  endtask

  always @(posedge clk_i) begin
    bin_result_t exp_r;
    if (rst_ni) begin
      if (in_valid_i && in_ready_i) wilson_q.push_back(wilson_bin(n_total_i, n_passed_i));
      if (out_valid_i && out_ready_i) begin
        if (wilson_q.size() == 0) begin
          report_mismatch("unexpected result", 1, 0);
        end else begin
          exp_r = wilson_q.pop_front();
          if (efficiency_i !== exp_r.eff) report_mismatch("efficiency", efficiency_i, exp_r.eff);
          if (error_up_i !== exp_r.up) report_mismatch("error_up", error_up_i, exp_r.up);
          if (error_down_i !== exp_r.down)
            report_mismatch("error_down", error_down_i, exp_r.down);
          if (invalid_i !== exp_r.inv) report_mismatch("invalid", invalid_i, exp_r.inv);
        end
      end
    end
  end

endmodule

`default_nettype wire

// File: tb/binomial_efficiency_interval_test.sv
// ----------------------------------------------------------------------------
// binomial_efficiency_interval_test: stimulus and verdict for the interval block
// Directed corner bins, then random bins with random idling on both channels;
// a checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
`default_nettype none

module binomial_efficiency_interval_test;
  import bei_pkg::*;

  localparam int RandomBins = 1150;
  localparam int StallLimit = 20000;  // cycles with no request moving
  localparam int DrainWait  = 150;    // extra wait after the last pending result

  logic                    clk_i       = 1'b0;
  logic                    rst_ni      = 1'b0;
  logic                    in_valid_i  = 1'b0;
  logic                    in_ready_o;
  logic [CountBitsDef-1:0] n_total_i   = '0;
  logic [CountBitsDef-1:0] n_passed_i  = '0;
  logic                    out_valid_o;
  logic                    out_ready_i = 1'b0;
  logic [FracBitsDef:0]    efficiency_o;
  logic [FracBitsDef:0]    error_up_o;
  logic [FracBitsDef:0]    error_down_o;
  logic                    invalid_o;
  int                      fail_count;
  int                      pending;
  int                      quiet_cnt = 0;
  bit                      no_idle   = 1'b0;  // set during the stretch without gaps

  always #10 clk_i = ~clk_i;

  binomial_efficiency_interval dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .n_total_i, .n_passed_i,
    .out_valid_o, .out_ready_i, .efficiency_o, .error_up_o, .error_down_o, .invalid_o
  );

  bei_result_checker u_checker (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_i(in_ready_o), .n_total_i, .n_passed_i,
    .out_valid_i(out_valid_o), .out_ready_i,
    .efficiency_i(efficiency_o), .error_up_i(error_up_o), .error_down_i(error_down_o),
    .invalid_i(invalid_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // Result side: back-pressure about 35% of cycles, except in the quiet stretch.
  always @(posedge clk_i) begin
    out_ready_i <= no_idle ? 1'b1 : ($urandom_range(99) >= 35);
  end

  // Watchdog: counts cycles in which neither channel moves a request.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cnt <= 0;
    else quiet_cnt <= quiet_cnt + 1;
    if (quiet_cnt >= StallLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // One request: optional gap, then hold valid and payload until ready is seen.
  task automatic send_bin(logic [31:0] n, logic [31:0] k);
    bit taken;
    while (!no_idle && $urandom_range(99) < 35) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    n_total_i  <= n;
    n_passed_i <= k;
    do begin
      @(negedge clk_i);
      taken = in_ready_o;
      @(posedge clk_i);
    end while (!taken);
  endtask

  initial begin
    logic [31:0] n;
    logic [31:0] k;
    int          pick;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty bin, passed above total (with and without zero total), full bins,
    // extremes of both counts, and the symmetric point k = n/2.
    send_bin(0, 0);
    send_bin(0, 1);
    send_bin(0, 32'hFFFF_FFFF);
    send_bin(1, 0);
    send_bin(1, 1);
    send_bin(1, 2);
    send_bin(2, 1);
    send_bin(3, 1);
    send_bin(100, 37);
    send_bin(100, 100);
    send_bin(32'hFFFF_FFFF, 0);
    send_bin(32'hFFFF_FFFF, 1);
    send_bin(32'hFFFF_FFFF, 32'h7FFF_FFFF);
    send_bin(32'hFFFF_FFFF, 32'h8000_0000);
    send_bin(32'hFFFF_FFFF, 32'hFFFF_FFFE);
    send_bin(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_bin(32'hFFFF_FFFE, 32'hFFFF_FFFF);
    send_bin(32'h8000_0000, 32'h4000_0000);
    send_bin(32'h5555_5555, 32'h2AAA_AAAA);
    send_bin(32'hAAAA_AAAA, 32'h5555_5555);

    for (int i = 0; i < RandomBins; i++) begin
      no_idle = (i >= 400 && i < 560);
      pick = $urandom_range(99);
      if (pick < 40) begin
        n = $urandom_range(1000, 1);
        k = $urandom_range(n, 0);
      end else if (pick < 70) begin
        n = $urandom;
        k = 32'((64'($urandom) * (64'(n) + 1)) >> 32);
      end else if (pick < 80) begin
        n = $urandom;
        k = $urandom_range(1) ? n : 32'd0;
      end else if (pick < 90) begin
        n = $urandom;
        if (n == 32'hFFFF_FFFF) n = 32'hFFFF_FFFE;
        k = n + 1 + ($urandom % (32'hFFFF_FFFF - n));
      end else begin
        n = $urandom;
        k = $urandom;
      end
      send_bin(n, k);
    end
    no_idle = 1'b0;
    in_valid_i <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    if (fail_count == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule

`default_nettype wire

// File: files.f
rtl/core/bei_pkg.sv
rtl/core/bei_div.sv
rtl/core/bei_sqrt.sv
rtl/core/binomial_efficiency_interval.sv
tb/bei_result_checker.sv
tb/binomial_efficiency_interval_test.sv
